FILE: design/ufc_pkg.sv
// Shared constants, status codes and result type for the UHF reader frame checker.
`default_nettype none

package ufc_pkg;

	localparam int BYTE_W  = 8;
	localparam int IDX_W   = 16;
	localparam int CNT_W   = 17;
	localparam int STAT_W  = 3;

	localparam logic [BYTE_W-1:0] HDR_MARK = 8'hBB;
	localparam logic [BYTE_W-1:0] END_MARK = 8'h7E;

	// Frame overhead: header, type, command, two length bytes, checksum, end.
	localparam logic [CNT_W:0] MIN_FRAME   = 18'd7;
	localparam logic [CNT_W-1:0] PARAM_START = 17'd5;
	// Last byte position whose parameter index still fits in 16 bits.
	localparam logic [CNT_W-1:0] PARAM_LAST  = 17'h10004;
	localparam logic [CNT_W-1:0] COUNT_MAX   = 17'h1FFFF;

	// Byte positions of the header fields.
	localparam logic [CNT_W-1:0] POS_HDR    = 17'd0;
	localparam logic [CNT_W-1:0] POS_TYPE   = 17'd1;
	localparam logic [CNT_W-1:0] POS_CMD    = 17'd2;
	localparam logic [CNT_W-1:0] POS_LEN_HI = 17'd3;
	localparam logic [CNT_W-1:0] POS_LEN_LO = 17'd4;

	localparam logic KIND_PARAM  = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
	localparam logic [STAT_W-1:0] STAT_SHORT     = 3'd1;
	localparam logic [STAT_W-1:0] STAT_BAD_HDR   = 3'd2;
	localparam logic [STAT_W-1:0] STAT_BAD_END   = 3'd3;
	localparam logic [STAT_W-1:0] STAT_LEN_ERR   = 3'd4;
	localparam logic [STAT_W-1:0] STAT_CHECKSUM  = 3'd5;

	typedef struct packed {
		logic              item_kind;
		logic [BYTE_W-1:0] param_byte;
		logic [IDX_W-1:0]  param_index;
		logic [STAT_W-1:0] parse_status;
		logic [BYTE_W-1:0] frame_type;
		logic [BYTE_W-1:0] command;
		logic [IDX_W-1:0]  declared_len;
	} res_t;

endpackage

`default_nettype wire

FILE: design/ufc_byte_if.sv
// Byte channel: one received byte per transaction with an end-of-buffer flag.
`default_nettype none

interface ufc_byte_if;
	logic                       valid;
	logic                       ready;
	logic [ufc_pkg::BYTE_W-1:0] rx_byte;
	logic                       buf_last;

	modport source (output valid, output rx_byte, output buf_last, input ready);
	modport sink   (input valid, input rx_byte, input buf_last, output ready);
endinterface

`default_nettype wire

FILE: design/ufc_result_if.sv
// Result channel: tentative parameter bytes and end-of-buffer status.
`default_nettype none

interface ufc_result_if;
	logic                       valid;
	logic                       ready;
	logic                       item_kind;
	logic [ufc_pkg::BYTE_W-1:0] param_byte;
	logic [ufc_pkg::IDX_W-1:0]  param_index;
	logic [ufc_pkg::STAT_W-1:0] parse_status;
	logic [ufc_pkg::BYTE_W-1:0] frame_type;
	logic [ufc_pkg::BYTE_W-1:0] command;
	logic [ufc_pkg::IDX_W-1:0]  declared_len;

	modport source (output valid, output item_kind, output param_byte, output param_index,
		output parse_status, output frame_type, output command, output declared_len,
		input ready);
	modport sink   (input valid, input item_kind, input param_byte, input param_index,
		input parse_status, input frame_type, input command, input declared_len,
		output ready);
endinterface

`default_nettype wire

FILE: design/uhf_reader_frame_checker.sv
// Top level of the UHF reader frame checker: input register, checker, result register.
// Takes one byte per transaction and can accept a byte every cycle while the
// result side takes its results. Each byte passes through an input register,
// then the frame checker updates its counters, header fields and 8-bit running
// sum and loads the result register, from which the result is offered on the
// output. Parameter bytes (position 5 on, index up to 65535) come out as
// tentative items; the byte flagged last gives one status item with type,
// command and declared length, and resets the frame state. Backpressure on the
// result side stalls both registers; bytes that give no result still need a
// free slot.
`default_nettype none

module uhf_reader_frame_checker (
	input  wire logic     clk,
	input  wire logic     arst_n,
	ufc_byte_if.sink      rx_in,
	ufc_result_if.source  res_out
);
	import ufc_pkg::*;

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              last_s1;
	logic              res_valid_q;
	res_t              res_q;
	res_t              core_res;
	logic              core_emit;
	logic              advance;
	logic              step;

	assign advance     = !res_valid_q || res_out.ready;
	assign step        = valid_s1 && advance;
	assign rx_in.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_in.ready) begin
			valid_s1 <= rx_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_in.ready && rx_in.valid) begin
			byte_s1 <= rx_in.rx_byte;
			last_s1 <= rx_in.buf_last;
		end
	end

	ufc_check u_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.rx_byte  (byte_s1),
		.buf_last (last_s1),
		.res      (core_res),
		.emit     (core_emit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= step && core_emit;
		end
	end

	always_ff @(posedge clk) begin
		if (step && core_emit) begin
			res_q <= core_res;
		end
	end

	assign res_out.valid        = res_valid_q;
	assign res_out.item_kind    = res_q.item_kind;
	assign res_out.param_byte   = res_q.param_byte;
	assign res_out.param_index  = res_q.param_index;
	assign res_out.parse_status = res_q.parse_status;
	assign res_out.frame_type   = res_q.frame_type;
	assign res_out.command      = res_q.command;
	assign res_out.declared_len = res_q.declared_len;

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(byte_s1) && $stable(last_s1))
		else $error("input stage lost a byte under stall");

	a_param_fields: assert property (@(posedge clk) disable iff (!arst_n)
		res_out.valid && res_out.item_kind == KIND_PARAM |->
		res_out.parse_status == STAT_OK && res_out.frame_type == '0 &&
		res_out.command == '0 && res_out.declared_len == '0)
		else $error("parameter item carries status fields");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_out.valid && res_out.item_kind == KIND_STATUS |->
		res_out.parse_status <= STAT_CHECKSUM && res_out.param_byte == '0 &&
		res_out.param_index == '0)
		else $error("status item malformed");

endmodule

`default_nettype wire

FILE: design/ufc_check.sv
// Frame state registers and the per-byte check and result logic.
`default_nettype none

module ufc_check (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       step,
	input  wire logic [ufc_pkg::BYTE_W-1:0] rx_byte,
	input  wire logic                       buf_last,
	output ufc_pkg::res_t                   res,
	output logic                            emit
);
	import ufc_pkg::*;

	logic [CNT_W-1:0]  byte_count_q;
	logic [BYTE_W-1:0] first_byte_q;
	logic [BYTE_W-1:0] type_q;
	logic [BYTE_W-1:0] command_q;
	logic [IDX_W-1:0]  length_q;
	logic [BYTE_W-1:0] sum_q;
	logic [BYTE_W-1:0] dly0_q;
	logic [BYTE_W-1:0] dly1_q;

	logic [BYTE_W-1:0] first_n;
	logic [BYTE_W-1:0] type_n;
	logic [BYTE_W-1:0] command_n;
	logic [IDX_W-1:0]  length_n;
	logic [BYTE_W-1:0] sum_n;
	logic [CNT_W:0]    total;
	logic [CNT_W-1:0]  rel_idx;
	logic [STAT_W-1:0] status;
	logic              in_params;

	always_comb begin
		first_n   = (byte_count_q == POS_HDR)  ? rx_byte : first_byte_q;
		type_n    = (byte_count_q == POS_TYPE) ? rx_byte : type_q;
		command_n = (byte_count_q == POS_CMD)  ? rx_byte : command_q;
		length_n  = length_q;
		if (byte_count_q == POS_LEN_HI) begin
			length_n = {rx_byte, length_q[BYTE_W-1:0]};
		end else if (byte_count_q == POS_LEN_LO) begin
			length_n = {length_q[IDX_W-1:BYTE_W], rx_byte};
		end
		// The sum trails the input by two bytes so it covers type through parameters.
		sum_n = (byte_count_q >= POS_LEN_HI) ? sum_q + dly1_q : sum_q;

		total = {1'b0, byte_count_q} + 18'd1;
		if (total < MIN_FRAME) begin
			status = STAT_SHORT;
		end else if (first_n != HDR_MARK) begin
			status = STAT_BAD_HDR;
		end else if (rx_byte != END_MARK) begin
			status = STAT_BAD_END;
		end else if (total != MIN_FRAME + {2'b00, length_n}) begin
			status = STAT_LEN_ERR;
		end else if (dly0_q != sum_n) begin
			status = STAT_CHECKSUM;
		end else begin
			status = STAT_OK;
		end

		rel_idx   = byte_count_q - PARAM_START;
		in_params = (byte_count_q >= PARAM_START) && (byte_count_q <= PARAM_LAST);

		res = '0;
		if (buf_last) begin
			emit             = 1'b1;
			res.item_kind    = KIND_STATUS;
			res.parse_status = status;
			res.frame_type   = type_n;
			res.command      = command_n;
			res.declared_len = length_n;
		end else begin
			emit            = in_params;
			res.item_kind   = KIND_PARAM;
			res.param_byte  = rx_byte;
			res.param_index = rel_idx[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			first_byte_q <= '0;
			type_q       <= '0;
			command_q    <= '0;
			length_q     <= '0;
			sum_q        <= '0;
			dly0_q       <= '0;
			dly1_q       <= '0;
		end else if (step) begin
			if (buf_last) begin
				// End of buffer: drop all frame state for the next one.
				byte_count_q <= '0;
				first_byte_q <= '0;
				type_q       <= '0;
				command_q    <= '0;
				length_q     <= '0;
				sum_q        <= '0;
				dly0_q       <= '0;
				dly1_q       <= '0;
			end else begin
				if (byte_count_q != COUNT_MAX) begin
					byte_count_q <= byte_count_q + 17'd1;
				end
				first_byte_q <= first_n;
				type_q       <= type_n;
				command_q    <= command_n;
				length_q     <= length_n;
				sum_q        <= sum_n;
				dly0_q       <= rx_byte;
				dly1_q       <= dly0_q;
			end
		end
	end

	a_clear_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		step && buf_last |=> byte_count_q == '0 && sum_q == '0)
		else $error("frame state not cleared after last byte");

	a_no_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		step && !buf_last && byte_count_q == COUNT_MAX |=> byte_count_q == COUNT_MAX)
		else $error("byte count wrapped");

	a_short_status: assert property (@(posedge clk) disable iff (!arst_n)
		buf_last && byte_count_q < 17'd6 |-> status == STAT_SHORT)
		else $error("short buffer not flagged");

endmodule

`default_nettype wire

FILE: verif/ufc_frame_monitor.sv
// Frame checker monitor: predicts results from accepted bytes and compares them.
module ufc_frame_monitor (
	input  wire logic clk,
	input  wire logic arst_n,
	ufc_byte_if       rx,
	ufc_result_if     res,
	output int        fail_count,
	output int        pending
);
	import ufc_pkg::*;

	localparam int REPORT_MAX = 10;

	res_t frame_results_due[$];
	res_t want;
	res_t got;

	logic [CNT_W-1:0]  byte_pos;
	logic [BYTE_W-1:0] hdr_seen;
	logic [BYTE_W-1:0] type_seen;
	logic [BYTE_W-1:0] cmd_seen;
	logic [IDX_W-1:0]  len_seen;
	logic [BYTE_W-1:0] sum_acc;
	logic [BYTE_W-1:0] prev1;
	logic [BYTE_W-1:0] prev2;

	task automatic clear_frame();
		byte_pos  = '0;
		hdr_seen  = '0;
		type_seen = '0;
		cmd_seen  = '0;
		len_seen  = '0;
		sum_acc   = '0;
		prev1     = '0;
		prev2     = '0;
	endtask

	// Advance the frame state by one byte and queue the result it causes.
	task automatic track_frame_byte(input logic [BYTE_W-1:0] b, input logic last);
		logic [CNT_W-1:0]  at;
		logic [CNT_W:0]    total;
		logic [STAT_W-1:0] status;
		res_t              r;
		at = byte_pos;
		r  = '0;
		if (at == POS_HDR) hdr_seen = b;
		else if (at == POS_TYPE) type_seen = b;
		else if (at == POS_CMD) cmd_seen = b;
		else if (at == POS_LEN_HI) len_seen[15:8] = b;
		else if (at == POS_LEN_LO) len_seen[7:0] = b;
		// sum lags two bytes behind so checksum and end marker stay out of it
		if (at >= POS_LEN_HI) sum_acc = sum_acc + prev2;
		if (last) begin
			total = {1'b0, at} + 1'b1;
			if (total < MIN_FRAME) status = STAT_SHORT;
			else if (hdr_seen != HDR_MARK) status = STAT_BAD_HDR;
			else if (b != END_MARK) status = STAT_BAD_END;
			else if (total != MIN_FRAME + {2'b00, len_seen}) status = STAT_LEN_ERR;
			else if (prev1 != sum_acc) status = STAT_CHECKSUM;
			else status = STAT_OK;
			r.item_kind    = KIND_STATUS;
			r.parse_status = status;
			r.frame_type   = type_seen;
			r.command      = cmd_seen;
			r.declared_len = len_seen;
			frame_results_due.push_back(r);
			clear_frame();
		end else begin
			prev2 = prev1;
			prev1 = b;
			if (byte_pos != COUNT_MAX) byte_pos = byte_pos + 1'b1;
			if (at >= PARAM_START && at <= PARAM_LAST) begin
				r.item_kind   = KIND_PARAM;
				r.param_byte  = b;
				r.param_index = IDX_W'(at - PARAM_START);
				frame_results_due.push_back(r);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_frame();
			frame_results_due.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			if (rx.valid && rx.ready) track_frame_byte(rx.rx_byte, rx.buf_last);
			if (res.valid && res.ready) begin
				got.item_kind    = res.item_kind;
				got.param_byte   = res.param_byte;
				got.param_index  = res.param_index;
				got.parse_status = res.parse_status;
				got.frame_type   = res.frame_type;
				got.command      = res.command;
				got.declared_len = res.declared_len;
				if (frame_results_due.size() == 0) begin
					if (fail_count < REPORT_MAX)
						$display("%0t: result with nothing expected: %h", $realtime, got);
					fail_count++;
				end else begin
					want = frame_results_due.pop_front();
					if (got.item_kind !== want.item_kind
						|| got.param_byte !== want.param_byte
						|| got.param_index !== want.param_index
						|| got.parse_status !== want.parse_status
						|| got.frame_type !== want.frame_type
						|| got.command !== want.command
						|| got.declared_len !== want.declared_len) begin
						if (fail_count < REPORT_MAX) begin
							$display("%0t: mismatch (expected / actual)", $realtime);
							$display("  kind %0d/%0d byte %h/%h index %0d/%0d status %0d/%0d",
								want.item_kind, got.item_kind, want.param_byte,
								got.param_byte, want.param_index, got.param_index,
								want.parse_status, got.parse_status);
							$display("  type %h/%h command %h/%h length %0d/%0d",
								want.frame_type, got.frame_type, want.command,
								got.command, want.declared_len, got.declared_len);
						end
						fail_count++;
					end
				end
			end
			pending = frame_results_due.size();
		end
	end
endmodule

FILE: verif/uhf_reader_frame_checker_tb.sv
// Testbench top for the frame checker: clock, reset, byte stimulus and verdict.
module uhf_reader_frame_checker_tb;
	import ufc_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 10;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   fail_count;
	int   pending;
	int   src_idle_pct = 0;
	int   snk_idle_pct = 0;
	logic hold_req = 1'b0;
	int   quiet_cycles;

	logic [BYTE_W-1:0] frame_buf[$];

	ufc_byte_if   rx_ch();
	ufc_result_if res_ch();

	always #2 clk = ~clk;

	uhf_reader_frame_checker dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx_in   (rx_ch),
		.res_out (res_ch)
	);

	ufc_frame_monitor monitor (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx         (rx_ch),
		.res        (res_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// Offer one byte; entered and left at a falling edge.
	task automatic put_byte(input logic [BYTE_W-1:0] b, input logic last);
		while ($urandom_range(99) < src_idle_pct) begin
			rx_ch.valid <= 1'b0;
			@(negedge clk);
		end
		rx_ch.valid    <= 1'b1;
		rx_ch.rx_byte  <= b;
		rx_ch.buf_last <= last;
		@(posedge clk);
		while (!rx_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic put_frame();
		int i;
		for (i = 0; i < frame_buf.size(); i++)
			put_byte(frame_buf[i], i == frame_buf.size() - 1);
	endtask

	function automatic logic [BYTE_W-1:0] other_than(input logic [BYTE_W-1:0] mark);
		logic [BYTE_W-1:0] b;
		b = BYTE_W'($urandom_range(254));
		if (b >= mark) b = b + 1'b1;
		return b;
	endfunction

	// Mostly well-formed frames with random content, the rest broken or noise.
	function automatic void fill_rand_buffer();
		int                sel;
		int                plen;
		int                cut;
		int                i;
		logic [BYTE_W-1:0] csum;
		logic [IDX_W-1:0]  dlen;
		frame_buf.delete();
		sel  = $urandom_range(99);
		plen = $urandom_range(12);
		dlen = IDX_W'(plen);
		if (sel >= 55 && sel < 63) begin
			if ($urandom_range(1) == 1) dlen = IDX_W'(plen + 1);
			else dlen = IDX_W'($urandom);
			if (dlen == IDX_W'(plen)) dlen = dlen - 1'b1;
		end
		frame_buf.push_back((sel >= 77 && sel < 84) ? other_than(HDR_MARK) : HDR_MARK);
		frame_buf.push_back(BYTE_W'($urandom));
		frame_buf.push_back(BYTE_W'($urandom));
		frame_buf.push_back(dlen[15:8]);
		frame_buf.push_back(dlen[7:0]);
		for (i = 0; i < plen; i++) frame_buf.push_back(BYTE_W'($urandom));
		csum = '0;
		for (i = 1; i < frame_buf.size(); i++) csum = csum + frame_buf[i];
		if (sel >= 63 && sel < 70) csum = csum ^ BYTE_W'($urandom_range(1, 255));
		frame_buf.push_back(csum);
		frame_buf.push_back((sel >= 70 && sel < 77) ? other_than(END_MARK) : END_MARK);
		if (sel >= 84 && sel < 92) begin
			cut = $urandom_range(1, 6);
			while (frame_buf.size() > cut) void'(frame_buf.pop_back());
		end else if (sel >= 92) begin
			frame_buf.delete();
			cut = $urandom_range(1, 20);
			for (i = 0; i < cut; i++) frame_buf.push_back(BYTE_W'($urandom));
		end
	endfunction

	task automatic run_random(input int nbytes);
		int sent;
		sent = 0;
		while (sent < nbytes) begin
			fill_rand_buffer();
			sent += frame_buf.size();
			put_frame();
		end
	endtask

	initial begin
		res_ch.ready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				// hold off long enough for the block to fill and stall its input
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				res_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
			end
		end
	end

	initial begin
		quiet_cycles = 0;
		wait (arst_n);
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("uhf_reader_frame_checker_tb: errors");
		$finish;
	end

	initial begin
		rx_ch.valid    = 1'b0;
		rx_ch.rx_byte  = '0;
		rx_ch.buf_last = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		src_idle_pct = 21;
		snk_idle_pct = 83;
		// one-byte buffer, too short
		frame_buf = '{8'hFF};
		put_frame();
		frame_buf = '{HDR_MARK, 8'hFF, 8'h00, 8'h00, 8'h00, 8'hFF, END_MARK};
		put_frame();
		frame_buf = '{8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF, END_MARK};
		put_frame();
		// checksum byte is zero, but type, command and length sum to 46h: checksum error
		frame_buf = '{HDR_MARK, 8'h12, 8'h34, 8'h00, 8'h00, 8'h00, END_MARK};
		put_frame();
		run_random(530);

		src_idle_pct = 83;
		snk_idle_pct = 21;
		run_random(530);

		src_idle_pct = 0;
		snk_idle_pct = 0;
		hold_req = 1'b1;
		run_random(540);
		rx_ch.valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("uhf_reader_frame_checker_tb: clean");
		else
			$display("uhf_reader_frame_checker_tb: errors");
		$finish;
	end
endmodule

FILE: files.f
design/ufc_pkg.sv
design/ufc_byte_if.sv
design/ufc_result_if.sv
design/ufc_check.sv
design/uhf_reader_frame_checker.sv
verif/ufc_frame_monitor.sv
verif/uhf_reader_frame_checker_tb.sv
